// ===== src/nvt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nvt_pkg
// Shared types and constants of the vertex normal and tangent builder.
// ============================================================================
package nvt_pkg;

    localparam int NVT_VERTEX_DEPTH = 1024;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TRI   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic CFG_HAS_NORMALS  = 1'b0;
    localparam logic CFG_VERTEX_COUNT = 1'b1;

    localparam logic signed [15:0] UNIT_ONE     = 16'sd16384;
    localparam logic signed [15:0] HELPER_LIMIT = 16'sd16220;

    typedef struct packed {
        logic               start;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] vz;
    } nvt_norm_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
    } nvt_norm_resp_t;

endpackage

// ===== src/vertex_normal_tangent_builder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vertex_normal_tangent_builder
// Vertex table with area-weighted normal accumulation and unit normal and
// tangent queries.
// ============================================================================
// A load beat writes both RAMs without leaving the idle state. A triangle beat
// does three position reads, six products through one 33 by 33 multiplier and
// a read-modify-write of each corner's accumulator; a bad or skipped triangle
// does not leave the idle state. A query beat runs the shared normalizer
// twice (normal, then tangent): a one-bit-per-cycle scaling shift, 32 square
// root steps and 45 divider steps, though the normal run ends at once for a
// zero normal. The block takes a new beat only when it is idle; a finished
// result waits in the output register while the next beat is accepted.
module vertex_normal_tangent_builder
    import nvt_pkg::*;
#(
    parameter int VERTEX_DEPTH = NVT_VERTEX_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_slot, pos_x, pos_y, pos_z, in_norm_x, in_norm_y, in_norm_z,
    // tri_a, tri_b, tri_c, zero fill
    input  logic [263:0] s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // unit_norm_x, unit_norm_y, unit_norm_z, tangent_x, tangent_y, tangent_z,
    // bad_index_seen, zero fill
    output logic [103:0] m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_data
);

    localparam int          ADDR_W  = $clog2(VERTEX_DEPTH);
    localparam logic [20:0] DEPTH_L = 21'(VERTEX_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TRA    = 4'd1;
    localparam logic [3:0] S_TRB    = 4'd2;
    localparam logic [3:0] S_TRC    = 4'd3;
    localparam logic [3:0] S_TCAP   = 4'd4;
    localparam logic [3:0] S_TDIFF  = 4'd5;
    localparam logic [3:0] S_TMUL   = 4'd6;
    localparam logic [3:0] S_TCROSS = 4'd7;
    localparam logic [3:0] S_TAR    = 4'd8;
    localparam logic [3:0] S_TAW    = 4'd9;
    localparam logic [3:0] S_QRD    = 4'd10;
    localparam logic [3:0] S_QN     = 4'd11;
    localparam logic [3:0] S_QT     = 4'd12;
    localparam logic [3:0] S_QOUT   = 4'd13;

    logic [9:0]  in_slot;
    logic [19:0] in_a, in_b, in_c;
    logic        accept, slot_ok, idx_bad;
    logic [20:0] vc_ext;

    logic [3:0]                  state_reg, state_next;
    logic                        has_normals_reg;
    logic [10:0]                 vcount_reg;
    logic                        flag_reg, flag_next;
    logic [2:0][ADDR_W-1:0]      idx_reg, idx_next;
    logic [1:0]                  k_reg, k_next;
    logic [2:0]                  mcnt_reg, mcnt_next;
    logic [2:0][31:0]            pa_reg, pb_reg, pc_reg;
    logic [2:0][32:0]            u_reg, w_reg;
    logic signed [65:0]          prod_reg [6];
    logic [2:0][63:0]            cr_reg;
    logic                        qok_reg, qok_next;
    logic [2:0][15:0]            n_reg, t_reg;
    logic                        m_valid_reg, m_valid_next;
    logic [103:0]                m_data_reg, m_data_next;

    logic              pos_we, acc_we;
    logic [ADDR_W-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
    logic [95:0]       pos_wdata, pos_rdata;
    logic [191:0]      acc_wdata, acc_rdata;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [2:0][63:0]   cross_val;
    logic [2:0][63:0]   acc_sum;
    logic               out_free;

    nvt_norm_req_t  nreq;
    nvt_norm_resp_t nresp;
    logic [15:0]    abs_ny;

    assign in_slot  = s_tdata[9:0];
    assign in_a     = s_tdata[221:202];
    assign in_b     = s_tdata[241:222];
    assign in_c     = s_tdata[261:242];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign vc_ext   = {10'd0, vcount_reg};
    assign slot_ok  = ({11'd0, in_slot} < DEPTH_L);
    assign idx_bad  = ({1'b0, in_a} >= vc_ext) || ({1'b0, in_a} >= DEPTH_L)
                   || ({1'b0, in_b} >= vc_ext) || ({1'b0, in_b} >= DEPTH_L)
                   || ({1'b0, in_c} >= vc_ext) || ({1'b0, in_c} >= DEPTH_L);
    assign out_free = !m_valid_reg || m_tready;

    nvt_ram #(.WIDTH(96), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    nvt_ram #(.WIDTH(192), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    nvt_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (nreq),
        .resp    (nresp)
    );

    always_comb begin
        unique case (mcnt_reg)
            3'd0: begin mul_a = u_reg[1]; mul_b = w_reg[2]; end
            3'd1: begin mul_a = u_reg[2]; mul_b = w_reg[1]; end
            3'd2: begin mul_a = u_reg[2]; mul_b = w_reg[0]; end
            3'd3: begin mul_a = u_reg[0]; mul_b = w_reg[2]; end
            3'd4: begin mul_a = u_reg[0]; mul_b = w_reg[1]; end
            default: begin mul_a = u_reg[1]; mul_b = w_reg[0]; end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        logic signed [66:0] d;
        logic signed [64:0] s;
        for (int i = 0; i < 3; i++) begin
            d = {prod_reg[2*i][65], prod_reg[2*i]} - {prod_reg[2*i+1][65], prod_reg[2*i+1]};
            if ((d[66:63] == 4'b0000) || (d[66:63] == 4'b1111)) begin
                cross_val[i] = d[63:0];
            end else if (d[66]) begin
                cross_val[i] = {1'b1, 63'd0};
            end else begin
                cross_val[i] = {1'b0, {63{1'b1}}};
            end
            s = {acc_rdata[64*i+63], acc_rdata[64*i +: 64]} + {cr_reg[i][63], cr_reg[i]};
            if (s[64] != s[63]) begin
                acc_sum[i] = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                acc_sum[i] = s[63:0];
            end
        end
    end

    always_comb begin
        abs_ny     = nresp.ry[15] ? 16'(-nresp.ry) : nresp.ry;
        nreq.start = 1'b0;
        nreq.vx    = 64'sd0;
        nreq.vy    = 64'sd0;
        nreq.vz    = 64'sd0;
        if (state_reg == S_QRD) begin
            nreq.start = 1'b1;
            if (qok_reg) begin
                nreq.vx = acc_rdata[63:0];
                nreq.vy = acc_rdata[127:64];
                nreq.vz = acc_rdata[191:128];
            end
        end else if ((state_reg == S_QN) && nresp.done) begin
            nreq.start = 1'b1;
            if ($signed(abs_ny) <= HELPER_LIMIT) begin
                nreq.vx = 64'(nresp.rz);
                nreq.vz = -64'(nresp.rx);
            end else begin
                nreq.vy = -64'(nresp.rz);
                nreq.vz = 64'(nresp.ry);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        flag_next    = flag_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        mcnt_next    = mcnt_reg;
        qok_next     = qok_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        pos_we       = 1'b0;
        pos_waddr    = ADDR_W'(in_slot);
        pos_wdata    = s_tdata[105:10];
        pos_raddr    = idx_reg[0];
        acc_we       = 1'b0;
        acc_waddr    = ADDR_W'(in_slot);
        acc_wdata    = has_normals_reg ? {{32{s_tdata[201]}}, s_tdata[201:170],
                                          {32{s_tdata[169]}}, s_tdata[169:138],
                                          {32{s_tdata[137]}}, s_tdata[137:106]}
                                       : 192'd0;
        acc_raddr    = ADDR_W'(in_slot);
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority if (s_tuser == CMD_LOAD) begin
                        pos_we = slot_ok;
                        acc_we = slot_ok;
                    end else if (s_tuser == CMD_TRI) begin
                        idx_next = {ADDR_W'(in_c), ADDR_W'(in_b), ADDR_W'(in_a)};
                        if (idx_bad) begin
                            flag_next = 1'b1;
                        end else if (!has_normals_reg) begin
                            state_next = S_TRA;
                        end
                    end else if (s_tuser == CMD_QUERY) begin
                        qok_next   = slot_ok;
                        state_next = S_QRD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_TRA: begin
                pos_raddr  = idx_reg[0];
                state_next = S_TRB;
            end
            S_TRB: begin
                pos_raddr  = idx_reg[1];
                state_next = S_TRC;
            end
            S_TRC: begin
                pos_raddr  = idx_reg[2];
                state_next = S_TCAP;
            end
            S_TCAP: begin
                state_next = S_TDIFF;
            end
            S_TDIFF: begin
                mcnt_next  = 3'd0;
                state_next = S_TMUL;
            end
            S_TMUL: begin
                mcnt_next = mcnt_reg + 3'd1;
                if (mcnt_reg == 3'd5) begin
                    state_next = S_TCROSS;
                end
            end
            S_TCROSS: begin
                k_next     = 2'd0;
                state_next = S_TAR;
            end
            S_TAR: begin
                acc_raddr  = idx_reg[k_reg];
                state_next = S_TAW;
            end
            S_TAW: begin
                acc_we     = 1'b1;
                acc_waddr  = idx_reg[k_reg];
                acc_wdata  = {acc_sum[2], acc_sum[1], acc_sum[0]};
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? S_IDLE : S_TAR;
            end
            S_QRD: begin
                state_next = S_QN;
            end
            S_QN: begin
                if (nresp.done) begin
                    state_next = S_QT;
                end
            end
            S_QT: begin
                if (nresp.done) begin
                    state_next = S_QOUT;
                end
            end
            S_QOUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, flag_reg, t_reg[2], t_reg[1], t_reg[0],
                                    n_reg[2], n_reg[1], n_reg[0]};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            has_normals_reg <= 1'b0;
            vcount_reg      <= 11'd0;
            flag_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_HAS_NORMALS:  has_normals_reg <= cfg_data[0];
                    CFG_VERTEX_COUNT: vcount_reg      <= cfg_data;
                    default:          vcount_reg      <= vcount_reg;
                endcase
            end
        end
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        mcnt_reg   <= mcnt_next;
        qok_reg    <= qok_next;
        m_data_reg <= m_data_next;
        if (state_reg == S_TRB) begin
            pa_reg <= pos_rdata;
        end
        if (state_reg == S_TRC) begin
            pb_reg <= pos_rdata;
        end
        if (state_reg == S_TCAP) begin
            pc_reg <= pos_rdata;
        end
        if (state_reg == S_TDIFF) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= {pb_reg[i][31], pb_reg[i]} - {pa_reg[i][31], pa_reg[i]};
                w_reg[i] <= {pc_reg[i][31], pc_reg[i]} - {pa_reg[i][31], pa_reg[i]};
            end
        end
        if (state_reg == S_TMUL) begin
            prod_reg[mcnt_reg] <= mul_p;
        end
        if (state_reg == S_TCROSS) begin
            cr_reg <= cross_val;
        end
        if ((state_reg == S_QN) && nresp.done) begin
            n_reg <= {nresp.rz, nresp.ry, nresp.rx};
        end
        if ((state_reg == S_QT) && nresp.done) begin
            t_reg <= {nresp.rz, nresp.ry, nresp.rx};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_reg |=> flag_reg)
        else $error("bad index flag cleared");

    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == CMD_LOAD)) |=> (state_reg == S_IDLE))
        else $error("load beat did not finish in one cycle");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($signed(m_data_reg[15:0]) <= UNIT_ONE)
                     && ($signed(m_data_reg[15:0]) >= -UNIT_ONE)
                     && ($signed(m_data_reg[31:16]) <= UNIT_ONE)
                     && ($signed(m_data_reg[31:16]) >= -UNIT_ONE))
        else $error("unit normal out of range");

endmodule

// ===== src/nvt_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nvt_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module nvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/nvt_norm.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nvt_norm
// Iterative normalizer: scales a 64-bit vector one bit per cycle, sums the
// squares through one multiplier, takes a bit-serial square root and divides
// each component by a restoring divider into a Q1.14 unit vector.
// ============================================================================
module nvt_norm
    import nvt_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  nvt_norm_req_t  req,
    output nvt_norm_resp_t resp
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SCALE = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DINIT = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;
    localparam logic [2:0] N_DONE  = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [2:0][63:0]          m_reg, m_next;
    logic [2:0]                neg_reg, neg_next;
    logic [63:0]               top_reg, top_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic [59:0]               prod_reg, prod_next;
    logic [61:0]               sum_reg, sum_next;
    logic [62:0]               rn_reg, rn_next;
    logic [62:0]               res_reg, res_next;
    logic [62:0]               bit_reg, bit_next;
    logic [45:0]               rem_reg, rem_next;
    logic [45:0]               den_reg, den_next;
    logic [14:0]               q_reg, q_next;
    logic [3:0]                step_reg, step_next;
    logic [2:0][15:0]          r_reg, r_next;

    logic [2:0][63:0]          mag_in;
    logic [63:0]               max01, max_all;
    logic [62:0]               trial;
    logic [14:0]               q_new;
    logic [15:0]               q_signed;
    logic                      start_ok;

    always_comb begin
        mag_in[0] = req.vx[63] ? 64'(-req.vx) : 64'(req.vx);
        mag_in[1] = req.vy[63] ? 64'(-req.vy) : 64'(req.vy);
        mag_in[2] = req.vz[63] ? 64'(-req.vz) : 64'(req.vz);
        max01     = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
        max_all   = (max01 > mag_in[2]) ? max01 : mag_in[2];
        trial     = res_reg + bit_reg;
        q_new     = {q_reg[13:0], (rem_reg >= den_reg)};
        q_signed  = neg_reg[cnt_reg] ? 16'(-{1'b0, q_new}) : {1'b0, q_new};
        start_ok  = req.start && ((state_reg == N_IDLE) || (state_reg == N_DONE));
    end

    always_comb begin
        state_next = state_reg;
        m_next     = m_reg;
        neg_next   = neg_reg;
        top_next   = top_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        sum_next   = sum_reg;
        rn_next    = rn_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        r_next     = r_reg;
        unique case (state_reg)
            N_IDLE, N_DONE: begin
                if (start_ok) begin
                    m_next   = mag_in;
                    neg_next = {req.vz[63], req.vy[63], req.vx[63]};
                    top_next = max_all;
                    if (max_all == 64'd0) begin
                        r_next     = {16'd0, UNIT_ONE, 16'd0};
                        state_next = N_DONE;
                    end else begin
                        state_next = N_SCALE;
                    end
                end else begin
                    state_next = N_IDLE;
                end
            end
            N_SCALE: begin
                if (top_reg[63:30] != 34'd0) begin
                    top_next = top_reg >> 1;
                    for (int i = 0; i < 3; i++) begin
                        m_next[i] = m_reg[i] >> 1;
                    end
                end else if (!top_reg[29]) begin
                    top_next = top_reg << 1;
                    for (int i = 0; i < 3; i++) begin
                        m_next[i] = m_reg[i] << 1;
                    end
                end else begin
                    cnt_next   = 2'd0;
                    sum_next   = 62'd0;
                    state_next = N_SQ;
                end
            end
            N_SQ: begin
                if (cnt_reg != 2'd3) begin
                    prod_next = m_reg[cnt_reg][29:0] * m_reg[cnt_reg][29:0];
                end
                if (cnt_reg != 2'd0) begin
                    sum_next = sum_reg + 62'(prod_reg);
                end
                if (cnt_reg == 2'd3) begin
                    rn_next    = 63'(sum_reg) + 63'(prod_reg);
                    res_next   = 63'd0;
                    bit_next   = 63'd1 << 62;
                    state_next = N_SQRT;
                end else begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            N_SQRT: begin
                if (rn_reg >= trial) begin
                    rn_next  = rn_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    cnt_next   = 2'd0;
                    state_next = N_DINIT;
                end
            end
            N_DINIT: begin
                rem_next   = (46'(m_reg[cnt_reg][29:0]) << 14) + 46'(res_reg[31:1]);
                den_next   = 46'(res_reg[31:0]) << 14;
                q_next     = 15'd0;
                step_next  = 4'd0;
                state_next = N_DIV;
            end
            N_DIV: begin
                if (rem_reg >= den_reg) begin
                    rem_next = rem_reg - den_reg;
                end
                den_next  = den_reg >> 1;
                q_next    = q_new;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd14) begin
                    r_next[cnt_reg] = q_signed;
                    cnt_next        = cnt_reg + 2'd1;
                    state_next      = (cnt_reg == 2'd2) ? N_DONE : N_DINIT;
                end
            end
            default: begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            state_reg <= state_next;
        end
        m_reg    <= m_next;
        neg_reg  <= neg_next;
        top_reg  <= top_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        rn_reg   <= rn_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        r_reg    <= r_next;
    end

    assign resp.done = (state_reg == N_DONE);
    assign resp.rx   = r_reg[0];
    assign resp.ry   = r_reg[1];
    assign resp.rz   = r_reg[2];

endmodule
